FILE: rtl/core/tbdd_pkg.sv
// Shared types and constants for the two-beam direction detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tbdd_pkg;

   localparam int COUNT_WIDTH_DEF = 8;
   localparam int PHASE_W         = 7;
   localparam int THRESH_W        = 8;
   localparam int CSR_DATA_W      = 8;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [THRESH_W-1:0] THRESH_RST       = 8'd20;
   localparam logic [PHASE_W-1:0]  WINDOW_START_RST = 7'd8;
   localparam logic [PHASE_W-1:0]  BURST_END_RST    = 7'd46;
   localparam logic [PHASE_W-1:0]  PERIOD_LAST_RST  = 7'd84;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TRIP_LEVEL   = 2'd0,
      REG_WINDOW_START = 2'd1,
      REG_BURST_END    = 2'd2,
      REG_PERIOD_LAST  = 2'd3
   } reg_index_type;

   // bit1 = beam A broken, bit0 = beam B broken
   typedef enum logic [1:0] {
      CODE_CLEAR  = 2'b00,
      CODE_B_ONLY = 2'b01,
      CODE_A_ONLY = 2'b10,
      CODE_BOTH   = 2'b11
   } broken_code_type;

   typedef struct packed {
      logic sensor_a;
      logic sensor_b;
   } req_type;

   typedef struct packed {
      logic ir_led;
      logic sampling;
      logic walk_in;
      logic walk_out;
   } rsp_type;

   typedef struct packed {
      logic [THRESH_W-1:0] trip_level;
      logic [PHASE_W-1:0]  window_start;
      logic [PHASE_W-1:0]  burst_end;
      logic [PHASE_W-1:0]  period_last;
   } cfg_type;

   // Burst sequencer status for the tick being processed
   typedef struct packed {
      logic led;      // emitter level after the tick
      logic window;   // window flag after the tick
      logic closing;  // window falls on this tick
   } burst_type;

endpackage

`default_nettype wire

FILE: rtl/core/tbdd_csr.sv
// Configuration registers of the two-beam direction detector.
// Depends on tbdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbdd_csr
   import tbdd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_TRIP_LEVEL:   cfg_in.trip_level   = csr_data[THRESH_W-1:0];
            REG_WINDOW_START: cfg_in.window_start = csr_data[PHASE_W-1:0];
            REG_BURST_END:    cfg_in.burst_end    = csr_data[PHASE_W-1:0];
            REG_PERIOD_LAST:  cfg_in.period_last  = csr_data[PHASE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_level   <= THRESH_RST;
         cfg_ff.window_start <= WINDOW_START_RST;
         cfg_ff.burst_end    <= BURST_END_RST;
         cfg_ff.period_last  <= PERIOD_LAST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tbdd_burst.sv
// Phase counter, emitter toggle and sampling window latch.
// Depends on tbdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbdd_burst
   import tbdd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire cfg_type cfg,
   output burst_type    burst
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               led_ff, led_in;
   logic               window_ff, window_in;

   always_comb begin
      if (phase_ff <= cfg.burst_end) begin
         window_in = window_ff | (phase_ff >= cfg.window_start);
         led_in    = ~led_ff;
         phase_in  = phase_ff + PHASE_W'(1);
      end else begin
         window_in = 1'b0;
         led_in    = 1'b0;
         phase_in  = (phase_ff == cfg.period_last) ? '0 : phase_ff + PHASE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         led_ff    <= 1'b0;
         window_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         led_ff    <= led_in;
         window_ff <= window_in;
      end
   end

   assign burst.led     = led_in;
   assign burst.window  = window_in;
   assign burst.closing = window_ff & ~window_in;

endmodule

`default_nettype wire

FILE: rtl/core/tbdd_beam.sv
// Per-beam sample counters, break judgement and direction decision.
// Depends on tbdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbdd_beam
   import tbdd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire req_type             req,
   input  wire burst_type           burst,
   input  wire logic [THRESH_W-1:0] threshold,
   output logic                     walk_in,
   output logic                     walk_out
);

   localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] count_a_ff, count_a_in;
   logic [COUNT_WIDTH-1:0] count_b_ff, count_b_in;
   broken_code_type        code_ff, code_in;
   logic                   rearm_ff, rearm_in;
   broken_code_type        cur;
   logic                   still_wait;

   always_comb begin
      cur = broken_code_type'({
         (CMP_W'(count_a_ff) >= CMP_W'(threshold)),
         (CMP_W'(count_b_ff) >= CMP_W'(threshold))});
      still_wait = rearm_ff & (cur != CODE_CLEAR);
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      code_in    = code_ff;
      rearm_in   = rearm_ff;
      walk_in    = 1'b0;
      walk_out   = 1'b0;
      if (burst.window) begin
         if (req.sensor_a && count_a_ff != COUNT_MAX)
            count_a_in = count_a_ff + COUNT_WIDTH'(1);
         if (req.sensor_b && count_b_ff != COUNT_MAX)
            count_b_in = count_b_ff + COUNT_WIDTH'(1);
      end else if (burst.closing) begin
         count_a_in = '0;
         count_b_in = '0;
         rearm_in   = still_wait;
         if (!still_wait) begin
            walk_in  = (code_ff == CODE_CLEAR) && (cur == CODE_A_ONLY);
            walk_out = (code_ff == CODE_CLEAR) && (cur == CODE_B_ONLY);
            rearm_in = walk_in | walk_out;
            code_in  = cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         code_ff    <= CODE_CLEAR;
         rearm_ff   <= 1'b0;
      end else if (step) begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         code_ff    <= code_in;
         rearm_ff   <= rearm_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/two_beam_direction_detector.sv
// Top level of the two-beam direction detector: CSRs, burst sequencer,
// beam judge and result register. Depends on tbdd_pkg, tbdd_csr,
// tbdd_burst and tbdd_beam.
//
//   channel  ports                          direction  transfer
//   req      req_valid/req_ready/req_data   in         one tick, two sensor bits
//   rsp      rsp_valid/rsp_ready/rsp_data   out        one result per tick
//   csr      csr_write/csr_index/csr_data   in         write when csr_write high
//
// One tick per cycle unless a result stalls; a result appears in the cycle after its tick is taken.
// The result register lets a new tick in while the result it holds is taken.
// A stalled result blocks req only while rsp_ready is low.
// Synchronous reset restores register defaults and clears phase and counts.
`timescale 1ns / 1ps
`default_nettype none

module two_beam_direction_detector
   import tbdd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg;
   burst_type burst;
   logic      step;
   logic      walk_in, walk_out;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff, rsp_data_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   tbdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tbdd_burst u_burst (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg),
      .burst (burst)
   );

   tbdd_beam #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_beam (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_data),
      .burst     (burst),
      .threshold (cfg.trip_level),
      .walk_in   (walk_in),
      .walk_out  (walk_out)
   );

   always_comb begin
      rsp_data_in.ir_led   = burst.led;
      rsp_data_in.sampling = burst.window;
      rsp_data_in.walk_in  = walk_in;
      rsp_data_in.walk_out = walk_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.walk_in && rsp_data.walk_out))
      else $error("walk_in and walk_out in one result");

   a_event_outside_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.walk_in || rsp_data.walk_out)) |-> !rsp_data.sampling)
      else $error("direction event while sampling window open");

   a_transfer_yields_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted tick gave no result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_beam_direction_detector: a directed table of ticks
// and register writes, then random passage scenes under several burst settings.
// Every result is scored against a tick-level model of the barrier; needs tbdd_pkg and the RTL.

module tb_top
   import tbdd_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_MAX    = 13;

   typedef struct {
      bit            is_write;
      reg_index_type index;
      logic [7:0]    wdata;
      req_type       tick;
      bit            typed;
      rsp_type       want;
   } barrier_step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // barrier model: registers and state
   logic [THRESH_W-1:0]        thresh_q      = THRESH_RST;
   logic [PHASE_W-1:0]         win_start_q   = WINDOW_START_RST;
   logic [PHASE_W-1:0]         burst_end_q   = BURST_END_RST;
   logic [PHASE_W-1:0]         period_last_q = PERIOD_LAST_RST;
   logic [PHASE_W-1:0]         phase_q       = '0;
   logic                       led_q         = 1'b0;
   logic                       win_open      = 1'b0;
   logic                       rearming      = 1'b0;
   logic [COUNT_WIDTH_DEF-1:0] cnt_a         = '0;
   logic [COUNT_WIDTH_DEF-1:0] cnt_b         = '0;
   broken_code_type            beams_q       = CODE_CLEAR;

   rsp_type expected_rsp [$];

   int fail_count     = 0;
   int cycle_count    = 0;
   int ticks_sent     = 0;
   int results_seen   = 0;
   int writes_done    = 0;
   int walk_in_count  = 0;
   int walk_out_count = 0;
   int long_hold      = 0;
   int scene_span     = 85;
   bit calm           = 1'b0;

   // reset ticks, then a 3-tick period: two sampled ticks and a judging tick
   barrier_step_type steps [28] = '{
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b1, 4'b1000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b11, 1'b1, 4'b0000},
      '{1'b1, REG_TRIP_LEVEL,   8'h02, 2'b00, 1'b0, 4'b0000},
      '{1'b1, REG_WINDOW_START, 8'h80, 2'b00, 1'b0, 4'b0000},
      '{1'b1, REG_BURST_END,    8'h81, 2'b00, 1'b0, 4'b0000},
      '{1'b1, REG_PERIOD_LAST,  8'h82, 2'b00, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b1, 4'b0000},
      // A alone from idle
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b10, 1'b1, 4'b1100},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b10, 1'b1, 4'b0100},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b11, 1'b1, 4'b0010},
      // both while rearming
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b11, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b11, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      // clear
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      // B alone from idle
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b01, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b01, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b1, 4'b0001},
      // clear
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      // both from idle, then A alone without idle in between
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b11, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b11, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b10, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b10, 1'b0, 4'b0000},
      '{1'b0, REG_TRIP_LEVEL,   8'h00, 2'b00, 1'b0, 4'b0000}
   };

   two_beam_direction_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   // one tick of the barrier: burst sequencing, sampling, judging at window close
   function automatic rsp_type advance_barrier(req_type tick);
      rsp_type         o;
      logic            was_open;
      broken_code_type seen;
      o = '0;
      was_open = win_open;
      if (phase_q <= burst_end_q) begin
         if (phase_q >= win_start_q) win_open = 1'b1;
         led_q = ~led_q;
         phase_q = phase_q + 1'b1;
      end else begin
         win_open = 1'b0;
         led_q = 1'b0;
         phase_q = (phase_q == period_last_q) ? '0 : phase_q + 1'b1;
      end
      if (win_open) begin
         if (tick.sensor_a && cnt_a != '1) cnt_a = cnt_a + 1'b1;
         if (tick.sensor_b && cnt_b != '1) cnt_b = cnt_b + 1'b1;
      end else if (was_open) begin
         seen = broken_code_type'({cnt_a >= thresh_q, cnt_b >= thresh_q});
         cnt_a = '0;
         cnt_b = '0;
         if (rearming && seen == CODE_CLEAR) rearming = 1'b0;
         if (!rearming) begin
            if (beams_q == CODE_CLEAR && seen == CODE_A_ONLY) begin
               o.walk_in = 1'b1;
               rearming = 1'b1;
            end else if (beams_q == CODE_CLEAR && seen == CODE_B_ONLY) begin
               o.walk_out = 1'b1;
               rearming = 1'b1;
            end
            beams_q = seen;
         end
      end
      o.ir_led = led_q;
      o.sampling = win_open;
      return o;
   endfunction

   task automatic check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %b, got %b", name, want, got);
         fail_count++;
      end
   endtask

   task automatic push_tick(req_type tick, bit typed, rsp_type want);
      int      gap;
      rsp_type next;
      gap = idle_draw();
      if (csr_write) csr_write <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= tick;
      do @(posedge clock); while (!req_ready);
      next = advance_barrier(tick);
      if (typed) next = want;
      expected_rsp.push_back(next);
      ticks_sent++;
      if (next.walk_in) walk_in_count++;
      if (next.walk_out) walk_out_count++;
   endtask

   // drain every pending result, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type index, logic [7:0] value);
      if (!csr_write) settle();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      case (index)
         REG_TRIP_LEVEL:   thresh_q = value;
         REG_WINDOW_START: win_start_q = value[PHASE_W-1:0];
         REG_BURST_END:    burst_end_q = value[PHASE_W-1:0];
         REG_PERIOD_LAST:  period_last_q = value[PHASE_W-1:0];
         default: ;
      endcase
      writes_done++;
   endtask

   // top bit of the 7-bit registers is random: it must be dropped
   task automatic set_config(logic [7:0] thr, logic [6:0] ws, logic [6:0] be,
                             logic [6:0] pl);
      write_reg(REG_TRIP_LEVEL, thr);
      write_reg(REG_WINDOW_START, {1'($urandom_range(0, 1)), ws});
      write_reg(REG_BURST_END, {1'($urandom_range(0, 1)), be});
      write_reg(REG_PERIOD_LAST, {1'($urandom_range(0, 1)), pl});
      scene_span = (pl > be) ? int'(pl) + 1 : 128;
   endtask

   // people walking through: clear, first beam, both, second beam, clear; with random jumps, or one pinned scene
   task automatic run_scenes(int ticks, bit pin, broken_code_type pinned);
      broken_code_type scene;
      req_type         tick;
      bit              from_a;
      int              left;
      scene = CODE_CLEAR;
      from_a = 1'b1;
      left = 0;
      repeat (ticks) begin
         if (left == 0) begin
            if (pin) scene = pinned;
            else if ($urandom_range(0, 3) == 0) scene = broken_code_type'($urandom_range(0, 3));
            else begin
               case (scene)
                  CODE_CLEAR: begin
                     from_a = $urandom_range(0, 1);
                     scene = from_a ? CODE_A_ONLY : CODE_B_ONLY;
                  end
                  CODE_A_ONLY: scene = from_a ? CODE_BOTH : CODE_CLEAR;
                  CODE_BOTH:   scene = from_a ? CODE_B_ONLY : CODE_A_ONLY;
                  default:     scene = from_a ? CODE_CLEAR : CODE_BOTH;
               endcase
            end
            left = $urandom_range(1, 2 * scene_span);
         end
         left--;
         tick.sensor_a = scene[1] ^ ($urandom_range(0, 15) == 0);
         tick.sensor_b = scene[0] ^ ($urandom_range(0, 15) == 0);
         push_tick(tick, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_scoreboard
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            $error("rsp transfer with nothing pending: %b", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("ir_led", want.ir_led, rsp_data.ir_led);
            check_field("sampling", want.sampling, rsp_data.sampling);
            check_field("walk_in", want.walk_in, rsp_data.walk_in);
            check_field("walk_out", want.walk_out, rsp_data.walk_out);
         end
      end
   end

   initial begin : rsp_sink
      int hold;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold > 0) begin
            hold = long_hold;
            long_hold = 0;
         end else begin
            hold = idle_draw();
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int ws;
      int be;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= REG_TRIP_LEVEL;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].is_write) write_reg(steps[i].index, steps[i].wdata);
         else push_tick(steps[i].tick, steps[i].typed, steps[i].want);
      end

      // short periods: many judged windows in each run
      for (int i = 0; i < 6; i++) begin
         ws = $urandom_range(0, 3);
         be = ws + $urandom_range(0, 6);
         calm = (i % 3 == 1);
         set_config(8'($urandom_range(1, be - ws + 1)), 7'(ws), 7'(be),
                    7'(be + $urandom_range(1, 4)));
         run_scenes(100, 1'b0, CODE_CLEAR);
      end
      calm = 1'b0;

      // power-on timing; sink holds off while ticks keep coming
      set_config(THRESH_RST, WINDOW_START_RST, BURST_END_RST, PERIOD_LAST_RST);
      calm = 1'b1;
      long_hold = 90;
      run_scenes(60, 1'b0, CODE_CLEAR);
      calm = 1'b0;
      run_scenes(300, 1'b0, CODE_CLEAR);

      // zero threshold: every judged beam is broken
      set_config(8'd0, 7'd0, 7'd3, 7'd5);
      run_scenes(60, 1'b0, CODE_CLEAR);
      // longest closing window stays below the top threshold
      set_config(8'hFF, 7'd0, 7'd126, 7'd127);
      run_scenes(260, 1'b0, CODE_CLEAR);
      // window start past burst end
      set_config(8'd5, 7'd100, 7'd20, 7'd40);
      run_scenes(60, 1'b0, CODE_CLEAR);
      // window held open across wraps until the A count saturates, then closed
      set_config(8'hFF, 7'd0, 7'd127, 7'd127);
      run_scenes(300, 1'b1, CODE_A_ONLY);
      write_reg(REG_BURST_END, 8'd126);
      run_scenes(150, 1'b1, CODE_A_ONLY);
      // period end below the phase: counter wraps at 128
      set_config(8'd10, 7'd100, 7'd110, 7'd3);
      run_scenes(300, 1'b0, CODE_CLEAR);

      set_config(8'($urandom_range(0, 255)), 7'($urandom), 7'($urandom), 7'($urandom));
      run_scenes(150, 1'b0, CODE_CLEAR);
      ws = $urandom_range(0, 40);
      be = ws + $urandom_range(0, 40);
      set_config(8'($urandom_range(0, be - ws + 1)), 7'(ws), 7'(be),
                 7'($urandom_range(be + 1, 127)));
      run_scenes(150, 1'b0, CODE_CLEAR);

      settle();
      $display("Sent %0d ticks and checked %0d results over %0d register writes,",
               ticks_sent, results_seen, writes_done);
      $display("with %0d walk_in and %0d walk_out pulses among them.",
               walk_in_count, walk_out_count);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
